// ===== design/ialu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the signed 64-bit ALU: operation and status codes,
// pipeline depths and the result structs shared by the datapath modules.
package ialu_pkg;

  localparam int W          = 64;
  localparam int DIV_STAGES = W;
  localparam int MUL_STAGES = 4;
  localparam int MUL_DELAY  = DIV_STAGES - MUL_STAGES;

  localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ALL_ONE = {W{1'b1}};

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_REM    = 4'd4,
    OP_AND    = 4'd5,
    OP_OR     = 4'd6,
    OP_XOR    = 4'd7,
    OP_ANDNOT = 4'd8,
    OP_NEG    = 4'd9,
    OP_NOT    = 4'd10,
    OP_ABS    = 4'd11,
    OP_EVEN   = 4'd12,
    OP_ODD    = 4'd13
  } alu_op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OVF     = 2'd1,
    ST_ZDIV    = 2'd2,
    ST_INEXACT = 2'd3
  } alu_st_t;

  typedef struct packed {
    logic         ovf;
    logic [W-1:0] val;
  } mul_res_t;

  typedef struct packed {
    logic [W-1:0] q;
    logic [W-1:0] r;
  } div_res_t;

endpackage

// ===== design/ialu_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the ALU: operation code and two signed operands.
// Depends on nothing.
interface ialu_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

// ===== design/ialu_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the ALU: signed value and status code.
// Depends on nothing.
interface ialu_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic [1:0]         status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ===== design/ialu_mul.sv =====
`timescale 1ns / 1ps
// Pipelined 64x64 magnitude multiplier with signed overflow check, built
// from 32x32 partial products; delayed to match the divider. Uses ialu_pkg.
module ialu_mul (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ialu_pkg::W-1:0] ma,
  input  logic [ialu_pkg::W-1:0] mb,
  input  logic                  neg,
  output ialu_pkg::mul_res_t    res
);

  localparam int H = ialu_pkg::W / 2;

  logic [ialu_pkg::W-1:0]   ll_r, lh_r, hl_r, hh_r;
  logic                     neg1_r, neg2_r, neg3_r;
  logic [ialu_pkg::W:0]     mid_r;
  logic [ialu_pkg::W-1:0]   ll2_r, hh2_r;
  logic [2*ialu_pkg::W-1:0] p_r;
  ialu_pkg::mul_res_t       res4_nxt;
  ialu_pkg::mul_res_t       dly_r [ialu_pkg::MUL_DELAY+1];

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r   <= ma[H-1:0] * mb[H-1:0];
      lh_r   <= ma[H-1:0] * mb[ialu_pkg::W-1:H];
      hl_r   <= ma[ialu_pkg::W-1:H] * mb[H-1:0];
      hh_r   <= ma[ialu_pkg::W-1:H] * mb[ialu_pkg::W-1:H];
      neg1_r <= neg;
      mid_r  <= {1'b0, lh_r} + {1'b0, hl_r};
      ll2_r  <= ll_r;
      hh2_r  <= hh_r;
      neg2_r <= neg1_r;
      p_r    <= {hh2_r, ll2_r} + ({{(ialu_pkg::W-1){1'b0}}, mid_r} << H);
      neg3_r <= neg2_r;
    end
  end

  always_comb begin
    res4_nxt.ovf = (p_r[2*ialu_pkg::W-1:ialu_pkg::W] != '0) ||
                   (neg3_r ? (p_r[ialu_pkg::W-1:0] > ialu_pkg::MIN_VAL)
                           : (p_r[ialu_pkg::W-1:0] > (ialu_pkg::MIN_VAL - 1'b1)));
    res4_nxt.val = neg3_r ? ('0 - p_r[ialu_pkg::W-1:0]) : p_r[ialu_pkg::W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dly_r[0] <= res4_nxt;
      for (int i = 1; i <= ialu_pkg::MUL_DELAY; i++) begin
        dly_r[i] <= dly_r[i-1];
      end
    end
  end

  assign res = dly_r[ialu_pkg::MUL_DELAY];

endmodule

// ===== design/ialu_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider on 64-bit magnitudes, one quotient bit per
// stage. Uses ialu_pkg.
module ialu_div (
  input  logic                   clk,
  input  logic                   en,
  input  logic [ialu_pkg::W-1:0] dividend,
  input  logic [ialu_pkg::W-1:0] divisor,
  output ialu_pkg::div_res_t     res
);

  localparam int N = ialu_pkg::DIV_STAGES;

  logic [ialu_pkg::W-1:0] rem_r [N];
  logic [ialu_pkg::W-1:0] dq_r  [N];
  logic [ialu_pkg::W-1:0] d_r   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [ialu_pkg::W-1:0] rem_in, dq_in, d_in;
    logic [ialu_pkg::W:0]   shl, diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign d_in   = divisor;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign dq_in  = dq_r[k-1];
      assign d_in   = d_r[k-1];
    end

    assign shl  = {rem_in, dq_in[ialu_pkg::W-1]};
    assign diff = shl - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[k] <= d_in;
        if (!diff[ialu_pkg::W]) begin
          rem_r[k] <= diff[ialu_pkg::W-1:0];
          dq_r[k]  <= {dq_in[ialu_pkg::W-2:0], 1'b1};
        end else begin
          rem_r[k] <= shl[ialu_pkg::W-1:0];
          dq_r[k]  <= {dq_in[ialu_pkg::W-2:0], 1'b0};
        end
      end
    end
  end

  assign res.q = dq_r[N-1];
  assign res.r = rem_r[N-1];

endmodule

// ===== design/int64_alu_with_overflow_flags_core.sv =====
`timescale 1ns / 1ps
// Top level of the signed 64-bit ALU with status flags.
// Uses ialu_pkg, ialu_in_if, ialu_out_if, ialu_mul and ialu_div.
//
//   channel   dir  words                          handshake
//   in_word   in   kind, operand_a, operand_b     valid/ready
//   out_word  out  value, status                  valid/ready
//
// One word enters per cycle while the pipeline is not held; each result passes
// through the input stage, the 64-stage divider and the select stage.
// rst_n clears the valid bits and the two-entry output buffer.
// The whole pipeline holds only while the output buffer is full and not
// being drained; a waiting result does not block input otherwise.
module int64_alu_with_overflow_flags_core (
  input  logic       clk,
  input  logic       rst_n,
  ialu_in_if.sink    in_word,
  ialu_out_if.source out_word
);

  localparam int L = ialu_pkg::DIV_STAGES;

  logic                   en;
  logic                   push, pop;
  logic                   vld_r  [L+1];
  ialu_pkg::alu_op_t      kind_r [L+1];
  logic [ialu_pkg::W-1:0] a_r    [L+1];
  logic [ialu_pkg::W-1:0] b_r    [L+1];
  logic [ialu_pkg::W-1:0] ma_r, mb_r;
  logic                   neg_r;
  logic [ialu_pkg::W-1:0] in_a, in_b;
  ialu_pkg::mul_res_t     mul_res;
  ialu_pkg::div_res_t     div_res;

  logic [ialu_pkg::W-1:0] fa, fb, sum, dif, qs, rs;
  logic [ialu_pkg::W-1:0] val_nxt;
  ialu_pkg::alu_st_t      st_nxt;

  logic [ialu_pkg::W-1:0] fv_r [2];
  ialu_pkg::alu_st_t      fs_r [2];
  logic [1:0]             cnt_r;
  logic                   wp_r, rp_r;

  assign in_a = in_word.operand_a;
  assign in_b = in_word.operand_b;

  assign en            = (cnt_r != 2'd2) || out_word.ready;
  assign in_word.ready = en;
  assign push          = en && vld_r[L];
  assign pop           = out_word.valid && out_word.ready;

  // stage 0: register operands and magnitudes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= L; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_word.valid;
      for (int i = 1; i <= L; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_r[0] <= ialu_pkg::alu_op_t'(in_word.kind);
      a_r[0]    <= in_a;
      b_r[0]    <= in_b;
      ma_r      <= in_a[ialu_pkg::W-1] ? ('0 - in_a) : in_a;
      mb_r      <= in_b[ialu_pkg::W-1] ? ('0 - in_b) : in_b;
      neg_r     <= in_a[ialu_pkg::W-1] ^ in_b[ialu_pkg::W-1];
      for (int i = 1; i <= L; i++) begin
        kind_r[i] <= kind_r[i-1];
        a_r[i]    <= a_r[i-1];
        b_r[i]    <= b_r[i-1];
      end
    end
  end

  ialu_mul u_mul (
    .clk (clk),
    .en  (en),
    .ma  (ma_r),
    .mb  (mb_r),
    .neg (neg_r),
    .res (mul_res)
  );

  ialu_div u_div (
    .clk      (clk),
    .en       (en),
    .dividend (ma_r),
    .divisor  (mb_r),
    .res      (div_res)
  );

  // select stage
  assign fa  = a_r[L];
  assign fb  = b_r[L];
  assign sum = fa + fb;
  assign dif = fa - fb;
  assign qs  = (fa[ialu_pkg::W-1] ^ fb[ialu_pkg::W-1]) ? ('0 - div_res.q) : div_res.q;
  assign rs  = fa[ialu_pkg::W-1] ? ('0 - div_res.r) : div_res.r;

  always_comb begin
    val_nxt = '0;
    st_nxt  = ialu_pkg::ST_OK;
    case (kind_r[L])
      ialu_pkg::OP_ADD: begin
        if (((fa ^ sum) & (fb ^ sum)) >> (ialu_pkg::W-1) != '0) st_nxt = ialu_pkg::ST_OVF;
        else val_nxt = sum;
      end
      ialu_pkg::OP_SUB: begin
        if (((fa ^ fb) & (fa ^ dif)) >> (ialu_pkg::W-1) != '0) st_nxt = ialu_pkg::ST_OVF;
        else val_nxt = dif;
      end
      ialu_pkg::OP_MUL: begin
        if (mul_res.ovf) st_nxt = ialu_pkg::ST_OVF;
        else val_nxt = mul_res.val;
      end
      ialu_pkg::OP_DIV: begin
        if (fb == '0) st_nxt = ialu_pkg::ST_ZDIV;
        else if (fa == ialu_pkg::MIN_VAL && fb == ialu_pkg::ALL_ONE) st_nxt = ialu_pkg::ST_OVF;
        else if (div_res.r != '0) st_nxt = ialu_pkg::ST_INEXACT;
        else val_nxt = qs;
      end
      ialu_pkg::OP_REM: begin
        if (fb == '0) st_nxt = ialu_pkg::ST_ZDIV;
        else if (fb == ialu_pkg::ALL_ONE) val_nxt = '0;
        else val_nxt = rs;
      end
      ialu_pkg::OP_AND:    val_nxt = fa & fb;
      ialu_pkg::OP_OR:     val_nxt = fa | fb;
      ialu_pkg::OP_XOR:    val_nxt = fa ^ fb;
      ialu_pkg::OP_ANDNOT: val_nxt = fa & ~fb;
      ialu_pkg::OP_NEG: begin
        if (fa == ialu_pkg::MIN_VAL) st_nxt = ialu_pkg::ST_OVF;
        else val_nxt = '0 - fa;
      end
      ialu_pkg::OP_NOT:    val_nxt = ~fa;
      ialu_pkg::OP_ABS: begin
        if (fa == ialu_pkg::MIN_VAL) st_nxt = ialu_pkg::ST_OVF;
        else val_nxt = fa[ialu_pkg::W-1] ? ('0 - fa) : fa;
      end
      ialu_pkg::OP_EVEN:   val_nxt = {{(ialu_pkg::W-1){1'b0}}, ~fa[0]};
      ialu_pkg::OP_ODD:    val_nxt = {{(ialu_pkg::W-1){1'b0}}, fa[0]};
      default: begin
        val_nxt = '0;
        st_nxt  = ialu_pkg::ST_OK;
      end
    endcase
  end

  // output buffer: two words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fv_r[wp_r] <= val_nxt;
      fs_r[wp_r] <= st_nxt;
    end
  end

  assign out_word.valid  = (cnt_r != 2'd0);
  assign out_word.value  = fv_r[rp_r];
  assign out_word.status = fs_r[rp_r];

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && (out_word.status != ialu_pkg::ST_OK) |-> out_word.value == '0)
    else $error("nonzero value with error status");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> cnt_r == $past(cnt_r) + {1'b0, $past(push)} - {1'b0, $past(pop)})
    else $error("output buffer count slipped");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) && !out_word.ready |=> cnt_r == 2'd2 && $stable(vld_r[L]))
    else $error("pipeline moved while output buffer full");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd3) && !(push && !pop && cnt_r == 2'd2))
    else $error("output buffer overrun");
`endif

endmodule

// ===== bench/tb_alu_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the signed 64-bit ALU: watches both channels, predicts
// each result and compares value and status. Depends on ialu_pkg and the
// ialu_in_if / ialu_out_if interfaces.
module tb_alu_checker (
  input  logic clk,
  input  logic rst_n,
  ialu_in_if   in_word,
  ialu_out_if  out_word,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);

  typedef struct packed {
    logic [63:0]       value;
    ialu_pkg::alu_st_t status;
  } alu_res_t;

  alu_res_t expected_results[$];

  function automatic logic [63:0] abs_mag(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic alu_res_t compute_alu(logic [3:0] kind, logic [63:0] a,
                                           logic [63:0] b);
    alu_res_t         res;
    logic [63:0]      r;
    logic [127:0]     prod;
    logic [63:0]      mag;
    logic signed [63:0] sa, sb;
    logic             neg;
    res.value  = '0;
    res.status = ialu_pkg::ST_OK;
    sa = a;
    sb = b;
    case (kind)
      ialu_pkg::OP_ADD: begin
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63])) res.status = ialu_pkg::ST_OVF;
        else res.value = r;
      end
      ialu_pkg::OP_SUB: begin
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63])) res.status = ialu_pkg::ST_OVF;
        else res.value = r;
      end
      ialu_pkg::OP_MUL: begin
        neg  = a[63] ^ b[63];
        prod = abs_mag(a) * abs_mag(b);
        if (prod[127:64] != 0) res.status = ialu_pkg::ST_OVF;
        else if (neg ? (prod[63:0] > ialu_pkg::MIN_VAL)
                     : (prod[63:0] > ialu_pkg::MIN_VAL - 1))
          res.status = ialu_pkg::ST_OVF;
        else res.value = neg ? -prod[63:0] : prod[63:0];
      end
      ialu_pkg::OP_DIV: begin
        if (b == 0) res.status = ialu_pkg::ST_ZDIV;
        else if (a == ialu_pkg::MIN_VAL && b == ialu_pkg::ALL_ONE)
          res.status = ialu_pkg::ST_OVF;
        else if (sa % sb != 0) res.status = ialu_pkg::ST_INEXACT;
        else res.value = sa / sb;
      end
      ialu_pkg::OP_REM: begin
        if (b == 0) res.status = ialu_pkg::ST_ZDIV;
        else if (b == ialu_pkg::ALL_ONE) res.value = '0;
        else res.value = sa % sb;
      end
      ialu_pkg::OP_AND:    res.value = a & b;
      ialu_pkg::OP_OR:     res.value = a | b;
      ialu_pkg::OP_XOR:    res.value = a ^ b;
      ialu_pkg::OP_ANDNOT: res.value = a & ~b;
      ialu_pkg::OP_NEG: begin
        if (a == ialu_pkg::MIN_VAL) res.status = ialu_pkg::ST_OVF;
        else res.value = -a;
      end
      ialu_pkg::OP_NOT: res.value = ~a;
      ialu_pkg::OP_ABS: begin
        if (a == ialu_pkg::MIN_VAL) res.status = ialu_pkg::ST_OVF;
        else res.value = abs_mag(a);
      end
      ialu_pkg::OP_EVEN: res.value = {63'd0, ~a[0]};
      ialu_pkg::OP_ODD:  res.value = {63'd0, a[0]};
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    alu_res_t want;
    if (!rst_n) begin
      fail_count   = 0;
      result_count = 0;
    end else begin
      if (in_word.valid && in_word.ready)
        expected_results.push_back(compute_alu(in_word.kind, in_word.operand_a,
                                               in_word.operand_b));
      if (out_word.valid && out_word.ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected word", out_word.value, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_word.value !== want.value)
            report_mismatch("value", out_word.value, want.value);
          if (out_word.status !== want.status)
            report_mismatch("status", out_word.status, want.status);
        end
      end
    end
  end

endmodule

// ===== bench/tb_int64_alu_with_overflow_flags_core.sv =====
`timescale 1ns / 1ps
// Top of the signed 64-bit ALU bench: drives directed and random words with
// random idling and stalls, and gives the verdict. Uses ialu_pkg, the
// channel interfaces, tb_alu_checker and int64_alu_with_overflow_flags_core.
module tb_int64_alu_with_overflow_flags_core;

  localparam int LATENCY = 70;
  localparam int LIMIT   = 400000;

  logic clk;
  logic rst_n;
  int   fails, pending, results;
  int   cycles;
  int   send_idle_pct, recv_idle_pct;
  int   hold_cycles;
  logic hold_active;
  int   sent;

  ialu_in_if  in_word();
  ialu_out_if out_word();

  int64_alu_with_overflow_flags_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .out_word(out_word)
  );

  tb_alu_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_word      (in_word),
    .out_word     (out_word),
    .fail_count   (fails),
    .pending_count(pending),
    .result_count (results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_word.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_active && hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_word.ready <= 1'b0;
      end else begin
        if (hold_active) hold_active <= 1'b0;
        out_word.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9, 0))
      0: return ialu_pkg::MIN_VAL;
      1: return ialu_pkg::MIN_VAL - 1;
      2: return ialu_pkg::ALL_ONE;
      3: return 64'd0;
      4: return 64'd1;
      5: return {{32{$urandom_range(1, 0) ? 1'b1 : 1'b0}}, 32'($urandom)};
      6: return 64'(signed'($urandom_range(200, 0)) - 100);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_word(logic [3:0] kind, logic [63:0] a, logic [63:0] b);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid     <= 1'b1;
    in_word.kind      <= kind;
    in_word.operand_a <= a;
    in_word.operand_b <= b;
    do @(posedge clk); while (!in_word.ready);
    sent++;
  endtask

  task automatic send_random();
    logic [3:0]  kind;
    logic [63:0] a, b;
    kind = 4'($urandom_range(15, 0));
    a = pick_operand();
    b = pick_operand();
    // build exact quotients often so division results are seen
    if (kind == ialu_pkg::OP_DIV && $urandom_range(1, 0)) begin
      b = 64'(signed'($urandom_range(2000, 0)) - 1000);
      a = $signed(b) * $signed(64'(signed'($urandom_range(1 << 20, 0))));
    end
    send_word(kind, a, b);
  endtask

  task automatic drain();
    in_word.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    ialu_pkg::alu_op_t op;
    rst_n = 1'b0;
    in_word.valid = 1'b0;
    in_word.kind = '0;
    in_word.operand_a = '0;
    in_word.operand_b = '0;
    hold_active = 1'b0;
    hold_cycles = 0;
    sent = 0;
    send_idle_pct = 20;
    recv_idle_pct = 79;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(ialu_pkg::OP_ADD, 64'h7fff_ffff_ffff_ffff, 64'd1);
    send_word(ialu_pkg::OP_ADD, ialu_pkg::MIN_VAL, ialu_pkg::ALL_ONE);
    send_word(ialu_pkg::OP_SUB, ialu_pkg::MIN_VAL, 64'd1);
    send_word(ialu_pkg::OP_SUB, 64'd0, ialu_pkg::MIN_VAL);
    send_word(ialu_pkg::OP_MUL, ialu_pkg::MIN_VAL, 64'd1);
    send_word(ialu_pkg::OP_MUL, ialu_pkg::MIN_VAL, ialu_pkg::ALL_ONE);
    send_word(ialu_pkg::OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
    send_word(ialu_pkg::OP_MUL, 64'h1_0000_0000, 64'hffff_ffff_8000_0000);
    send_word(ialu_pkg::OP_DIV, 64'd7, 64'd0);
    send_word(ialu_pkg::OP_DIV, ialu_pkg::MIN_VAL, ialu_pkg::ALL_ONE);
    send_word(ialu_pkg::OP_DIV, 64'd7, 64'd2);
    send_word(ialu_pkg::OP_DIV, -64'd12, 64'd4);
    send_word(ialu_pkg::OP_REM, 64'd7, 64'd0);
    send_word(ialu_pkg::OP_REM, ialu_pkg::MIN_VAL, ialu_pkg::ALL_ONE);
    send_word(ialu_pkg::OP_REM, -64'd7, 64'd3);
    send_word(ialu_pkg::OP_REM, 64'd7, -64'd3);
    send_word(ialu_pkg::OP_NEG, ialu_pkg::MIN_VAL, 64'd0);
    send_word(ialu_pkg::OP_ABS, ialu_pkg::MIN_VAL, 64'd0);
    send_word(ialu_pkg::OP_ABS, -64'd5, 64'd0);
    send_word(4'd14, 64'd3, 64'd4);
    send_word(4'd15, ialu_pkg::ALL_ONE, ialu_pkg::ALL_ONE);
    for (int k = ialu_pkg::OP_AND; k <= ialu_pkg::OP_ODD; k++) begin
      op = ialu_pkg::alu_op_t'(k);
      send_word(op, {$urandom, $urandom}, {$urandom, $urandom});
    end
    drain();

    // long receiver hold-off while words keep coming
    hold_cycles = 300;
    hold_active = 1'b1;
    for (int i = 0; i < 120; i++) send_random();
    drain();

    for (int i = 0; i < 150; i++) send_random();
    send_idle_pct = 79;
    recv_idle_pct = 20;
    for (int i = 0; i < 150; i++) send_random();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 200; i++) send_random();
    drain();
    repeat (LATENCY) @(posedge clk);

    $display("Sent %0d words, checked %0d results across all ops and stall modes",
             sent, results);
    if (fails == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/ialu_pkg.sv
design/ialu_in_if.sv
design/ialu_out_if.sv
design/ialu_mul.sv
design/ialu_div.sv
design/int64_alu_with_overflow_flags_core.sv
bench/tb_alu_checker.sv
bench/tb_int64_alu_with_overflow_flags_core.sv
